/* rtl/shc_pkg.sv */
// Shared types, constants and round functions of the SHA-256 single-block hash core.
package shc_pkg;

   localparam int unsigned SHC_WORD_W       = 32;
   localparam int unsigned SHC_WINDOW_DEPTH = 16;
   localparam int unsigned SHC_ROUNDS       = 64;
   localparam int unsigned SHC_DIGEST_WORDS = 8;
   localparam int unsigned SHC_QUEUE_DEPTH  = 4;

   typedef logic [SHC_WORD_W-1:0] word_type;
   typedef logic [5:0]            round_type;
   typedef logic [2:0]            digest_idx_type;
   typedef logic [3:0]            word_idx_type;

   // One message word on its way from the front to the back, tagged with the end of its block.
   typedef struct packed {
      word_type word;
      logic     last;
   } queue_entry_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (SHC_WORD_W - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type init_hash(input digest_idx_type k);
      word_type h;
      case (k)
         3'd0:    h = 32'h6a09e667;
         3'd1:    h = 32'hbb67ae85;
         3'd2:    h = 32'h3c6ef372;
         3'd3:    h = 32'ha54ff53a;
         3'd4:    h = 32'h510e527f;
         3'd5:    h = 32'h9b05688c;
         3'd6:    h = 32'h1f83d9ab;
         default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type round_const(input round_type r);
      word_type c;
      case (r)
         6'd0:  c = 32'h428a2f98;  6'd1:  c = 32'h71374491;
         6'd2:  c = 32'hb5c0fbcf;  6'd3:  c = 32'he9b5dba5;
         6'd4:  c = 32'h3956c25b;  6'd5:  c = 32'h59f111f1;
         6'd6:  c = 32'h923f82a4;  6'd7:  c = 32'hab1c5ed5;
         6'd8:  c = 32'hd807aa98;  6'd9:  c = 32'h12835b01;
         6'd10: c = 32'h243185be;  6'd11: c = 32'h550c7dc3;
         6'd12: c = 32'h72be5d74;  6'd13: c = 32'h80deb1fe;
         6'd14: c = 32'h9bdc06a7;  6'd15: c = 32'hc19bf174;
         6'd16: c = 32'he49b69c1;  6'd17: c = 32'hefbe4786;
         6'd18: c = 32'h0fc19dc6;  6'd19: c = 32'h240ca1cc;
         6'd20: c = 32'h2de92c6f;  6'd21: c = 32'h4a7484aa;
         6'd22: c = 32'h5cb0a9dc;  6'd23: c = 32'h76f988da;
         6'd24: c = 32'h983e5152;  6'd25: c = 32'ha831c66d;
         6'd26: c = 32'hb00327c8;  6'd27: c = 32'hbf597fc7;
         6'd28: c = 32'hc6e00bf3;  6'd29: c = 32'hd5a79147;
         6'd30: c = 32'h06ca6351;  6'd31: c = 32'h14292967;
         6'd32: c = 32'h27b70a85;  6'd33: c = 32'h2e1b2138;
         6'd34: c = 32'h4d2c6dfc;  6'd35: c = 32'h53380d13;
         6'd36: c = 32'h650a7354;  6'd37: c = 32'h766a0abb;
         6'd38: c = 32'h81c2c92e;  6'd39: c = 32'h92722c85;
         6'd40: c = 32'ha2bfe8a1;  6'd41: c = 32'ha81a664b;
         6'd42: c = 32'hc24b8b70;  6'd43: c = 32'hc76c51a3;
         6'd44: c = 32'hd192e819;  6'd45: c = 32'hd6990624;
         6'd46: c = 32'hf40e3585;  6'd47: c = 32'h106aa070;
         6'd48: c = 32'h19a4c116;  6'd49: c = 32'h1e376c08;
         6'd50: c = 32'h2748774c;  6'd51: c = 32'h34b0bcb5;
         6'd52: c = 32'h391c0cb3;  6'd53: c = 32'h4ed8aa4a;
         6'd54: c = 32'h5b9cca4f;  6'd55: c = 32'h682e6ff3;
         6'd56: c = 32'h748f82ee;  6'd57: c = 32'h78a5636f;
         6'd58: c = 32'h84c87814;  6'd59: c = 32'h8cc70208;
         6'd60: c = 32'h90befffa;  6'd61: c = 32'ha4506ceb;
         6'd62: c = 32'hbef9a3f7;
         default: c = 32'hc67178f2;
      endcase
      return c;
   endfunction

endpackage

/* rtl/shc_front.sv */
// Front end: accepts message words and tags the sixteenth word of each block.
module shc_front
   import shc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  word_type        req_message_word,
   output logic            q_valid,
   input  logic            q_ready,
   output queue_entry_type q_entry
);

   word_idx_type word_idx_ff;
   word_idx_type word_idx_in;

   assign req_ready     = q_ready;
   assign q_valid       = req_valid;
   assign q_entry.word  = req_message_word;
   assign q_entry.last  = (word_idx_ff == word_idx_type'(SHC_WINDOW_DEPTH - 1));

   // The index wraps from fifteen to zero on its own, so each block starts afresh.
   always_comb begin
      word_idx_in = word_idx_ff;
      if (req_valid && q_ready) begin
         word_idx_in = word_idx_ff + word_idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_idx_ff <= '0;
      end else begin
         word_idx_ff <= word_idx_in;
      end
   end

endmodule

/* rtl/shc_queue.sv */
// Short FIFO of tagged message words between the front end and the round engine.
module shc_queue
   import shc_pkg::*;
#(
   parameter int unsigned DEPTH = SHC_QUEUE_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  queue_entry_type in_entry,
   output logic            out_valid,
   input  logic            out_ready,
   output queue_entry_type out_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff < CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/shc_back.sv */
// Round engine: schedule window, 64 compression rounds and the digest output register.
module shc_back
   import shc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_ready,
   input  queue_entry_type q_entry,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output word_type        rsp_digest_word,
   output digest_idx_type  rsp_digest_index,
   output logic            rsp_digest_last
);

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_ROUND = 3'b010,
      ST_DONE  = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   round_type      round_ff, round_in;
   word_type       window_ff [SHC_WINDOW_DEPTH];
   word_type       window_in [SHC_WINDOW_DEPTH];
   word_type       vars_ff   [SHC_DIGEST_WORDS];
   word_type       vars_in   [SHC_DIGEST_WORDS];
   word_type       digest_ff [SHC_DIGEST_WORDS];
   word_type       digest_in [SHC_DIGEST_WORDS];
   logic [3:0]     emit_count_ff, emit_count_in;
   digest_idx_type emit_idx_ff, emit_idx_in;

   word_type new_w;
   word_type ch;
   word_type maj;
   word_type t1;
   word_type t2;

   assign q_ready          = (state_ff == ST_LOAD);
   assign rsp_valid        = (emit_count_ff != '0);
   assign rsp_digest_word  = digest_ff[0];
   assign rsp_digest_index = emit_idx_ff;
   assign rsp_digest_last  = (emit_idx_ff == digest_idx_type'(SHC_DIGEST_WORDS - 1));

   // The window holds W[t] at the bottom; the word shifted in at the top is W[t+16].
   assign new_w = small_sigma1(window_ff[14]) + window_ff[9]
                + small_sigma0(window_ff[1]) + window_ff[0];
   assign ch    = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj   = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                ^ (vars_ff[1] & vars_ff[2]);
   assign t1    = vars_ff[7] + big_sigma1(vars_ff[4]) + ch + round_const(round_ff)
                + window_ff[0];
   assign t2    = big_sigma0(vars_ff[0]) + maj;

   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      window_in     = window_ff;
      vars_in       = vars_ff;
      digest_in     = digest_ff;
      emit_count_in = emit_count_ff;
      emit_idx_in   = emit_idx_ff;

      // The digest drains word by word while the next block is being loaded.
      if (rsp_valid && rsp_ready) begin
         for (int k = 0; k < SHC_DIGEST_WORDS - 1; k++) begin
            digest_in[k] = digest_ff[k+1];
         end
         emit_count_in = emit_count_ff - 4'd1;
         emit_idx_in   = emit_idx_ff + digest_idx_type'(1);
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               for (int k = 0; k < SHC_WINDOW_DEPTH - 1; k++) begin
                  window_in[k] = window_ff[k+1];
               end
               window_in[SHC_WINDOW_DEPTH-1] = q_entry.word;
               if (q_entry.last) begin
                  state_in = ST_ROUND;
                  round_in = '0;
               end
            end
         end
         ST_ROUND: begin
            for (int k = 0; k < SHC_WINDOW_DEPTH - 1; k++) begin
               window_in[k] = window_ff[k+1];
            end
            window_in[SHC_WINDOW_DEPTH-1] = new_w;
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = t1 + t2;
            round_in   = round_ff + round_type'(1);
            if (round_ff == round_type'(SHC_ROUNDS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Waits until the previous digest has left the output register.
            if (emit_count_ff == '0) begin
               for (int k = 0; k < SHC_DIGEST_WORDS; k++) begin
                  digest_in[k] = vars_ff[k] + init_hash(digest_idx_type'(k));
                  vars_in[k]   = init_hash(digest_idx_type'(k));
               end
               emit_count_in = 4'(SHC_DIGEST_WORDS);
               emit_idx_in   = '0;
               state_in      = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      digest_ff <= digest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         round_ff      <= '0;
         emit_count_ff <= '0;
         emit_idx_ff   <= '0;
         for (int k = 0; k < SHC_DIGEST_WORDS; k++) begin
            vars_ff[k] <= init_hash(digest_idx_type'(k));
         end
      end else begin
         state_ff      <= state_in;
         round_ff      <= round_in;
         emit_count_ff <= emit_count_in;
         emit_idx_ff   <= emit_idx_in;
         vars_ff       <= vars_in;
      end
   end

   a_last_round_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == round_type'(SHC_ROUNDS - 1)) |=> state_ff == ST_DONE)
      else $error("round engine did not finish after the last round");

   a_round_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff != '0) |-> $past(state_ff) == ST_ROUND)
      else $error("round counter not at zero on entry to the rounds");

   a_digest_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && emit_count_ff == '0)
      |=> rsp_valid && rsp_digest_index == '0 && state_ff == ST_LOAD)
      else $error("digest not presented from word zero after a block");

   a_drain_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_digest_last) |=> !rsp_valid)
      else $error("a new digest overwrote one still draining");

endmodule

/* rtl/sha256_single_block_hash_core.sv */
// Top level of the SHA-256 single-block hash core: front end, word queue and round engine.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_message_word[31:0]
//   rsp      out        rsp_valid / rsp_ready  rsp_digest_word[31:0], rsp_digest_index[2:0],
//                                              rsp_digest_last
//
// In the round engine a block loads its sixteen words from the queue, runs the 64 rounds
// at one round per cycle, and then adds the initial value into the digest.
// Words fill the queue while the engine runs its rounds; the sixteen words of the next block
// load while the eight digest words are still draining.
// Reset is synchronous and drops any partly received block.
// A stalled result side holds the finished digest; the next digest waits for it to drain.
module sha256_single_block_hash_core
   import shc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = SHC_QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  word_type       req_message_word,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output word_type       rsp_digest_word,
   output digest_idx_type rsp_digest_index,
   output logic           rsp_digest_last
);

   logic            front_valid;
   logic            front_ready;
   queue_entry_type front_entry;
   logic            back_valid;
   logic            back_ready;
   queue_entry_type back_entry;

   shc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_word (req_message_word),
      .q_valid          (front_valid),
      .q_ready          (front_ready),
      .q_entry          (front_entry)
   );

   shc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_entry  (front_entry),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_entry (back_entry)
   );

   shc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (back_valid),
      .q_ready          (back_ready),
      .q_entry          (back_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

endmodule

/* test/sha256_checker.sv */
// Digest predictor and result checker for the SHA-256 single-block hash core.
module sha256_checker
   import shc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_ready,
   input  word_type       req_message_word,
   input  logic           rsp_valid,
   input  logic           rsp_ready,
   input  word_type       rsp_digest_word,
   input  digest_idx_type rsp_digest_index,
   input  logic           rsp_digest_last,
   output int unsigned    error_count,
   output int unsigned    pending_count,
   output int unsigned    blocks_hashed,
   output int unsigned    words_checked
);

   localparam int unsigned REPORT_LIMIT = 10;

   // Word 0 sits in the most significant 32 bits of each table.
   localparam logic [SHC_ROUNDS*SHC_WORD_W-1:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [SHC_DIGEST_WORDS*SHC_WORD_W-1:0] START_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      word_type       word;
      digest_idx_type index;
      logic           last;
   } digest_item_type;

   digest_item_type expected_digest [$];
   word_type        block_words [SHC_WINDOW_DEPTH];
   int unsigned     words_held;
   int unsigned     mismatches;
   int unsigned     hashed;
   int unsigned     compared;

   function automatic word_type ror(input word_type x, input int unsigned n);
      logic [2*SHC_WORD_W-1:0] both;
      both = {x, x} >> n;
      return both[SHC_WORD_W-1:0];
   endfunction

   function automatic word_type rot_sum_a(input word_type x);
      return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction

   function automatic word_type rot_sum_e(input word_type x);
      return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction

   function automatic word_type sched_mix0(input word_type x);
      return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sched_mix1(input word_type x);
      return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type start_word(input int unsigned k);
      return START_HASH[(SHC_DIGEST_WORDS-1-k)*SHC_WORD_W +: SHC_WORD_W];
   endfunction

   // Hashes the sixteen held words from the fixed start value and queues the eight digest words.
   function automatic void predict_digest();
      word_type        sched [SHC_ROUNDS];
      word_type        v [SHC_DIGEST_WORDS];
      word_type        t1;
      word_type        t2;
      word_type        choose;
      word_type        major;
      digest_item_type item;
      for (int i = 0; i < SHC_ROUNDS; i++) begin
         if (i < SHC_WINDOW_DEPTH) begin
            sched[i] = block_words[i];
         end else begin
            sched[i] = sched_mix1(sched[i-2]) + sched[i-7] + sched_mix0(sched[i-15])
                     + sched[i-16];
         end
      end
      for (int k = 0; k < SHC_DIGEST_WORDS; k++) begin
         v[k] = start_word(k);
      end
      for (int r = 0; r < SHC_ROUNDS; r++) begin
         choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
         major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t1 = v[7] + rot_sum_e(v[4]) + choose
            + ROUND_K[(SHC_ROUNDS-1-r)*SHC_WORD_W +: SHC_WORD_W] + sched[r];
         t2 = rot_sum_a(v[0]) + major;
         for (int k = SHC_DIGEST_WORDS - 1; k > 0; k--) begin
            v[k] = v[k-1];
         end
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int k = 0; k < SHC_DIGEST_WORDS; k++) begin
         item.word  = v[k] + start_word(k);
         item.index = digest_idx_type'(k);
         item.last  = (k == SHC_DIGEST_WORDS - 1);
         expected_digest.push_back(item);
      end
   endfunction

   initial begin
      words_held = 0;
      mismatches = 0;
      hashed     = 0;
      compared   = 0;
   end

   always @(posedge clock) begin
      digest_item_type oldest;
      if (reset) begin
         words_held = 0;
         expected_digest.delete();
      end else begin
         if (req_valid && req_ready) begin
            block_words[words_held] = req_message_word;
            words_held++;
            if (words_held == SHC_WINDOW_DEPTH) begin
               predict_digest();
               words_held = 0;
               hashed++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_digest.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("checker: unexpected digest item: word %h index %0d last %b",
                           rsp_digest_word, rsp_digest_index, rsp_digest_last);
               end
            end else begin
               oldest = expected_digest.pop_front();
               compared++;
               if (oldest.word !== rsp_digest_word || oldest.index !== rsp_digest_index ||
                   oldest.last !== rsp_digest_last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("checker: expected word %h index %0d last %b, got %h %0d %b",
                              oldest.word, oldest.index, oldest.last,
                              rsp_digest_word, rsp_digest_index, rsp_digest_last);
                  end
               end
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_digest.size();
      blocks_hashed <= hashed;
      words_checked <= compared;
   end

endmodule

/* test/testbench.sv */
// Top of the SHA-256 single-block hash core testbench: clock, reset, stimulus and verdict.
module testbench;
   import shc_pkg::*;

   localparam int unsigned CLOCK_HALF     = 4;
   localparam int unsigned RESET_CYCLES   = 12;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned DRAIN_CYCLES   = 120;
   localparam int unsigned PHASE_BLOCKS   = 7;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   word_type       req_message_word;
   logic           rsp_valid;
   logic           rsp_ready;
   word_type       rsp_digest_word;
   digest_idx_type rsp_digest_index;
   logic           rsp_digest_last;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned blocks_hashed;
   int unsigned words_checked;
   int unsigned req_idle_pct = 36;
   int unsigned rsp_idle_pct = 73;
   int unsigned stall_cycles = 0;
   logic        hold_request = 1'b0;
   logic        hold_done    = 1'b0;

   sha256_single_block_hash_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_word (req_message_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

   sha256_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_word (req_message_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .blocks_hashed    (blocks_hashed),
      .words_checked    (words_checked)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Result side: random back-pressure, plus one long hold-off when the stimulus asks for it.
   initial begin : receiver
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("testbench: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Called just after a falling edge; returns just after the falling edge that follows acceptance.
   task automatic send_word(input word_type w);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_message_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_block(input word_type blk [SHC_WINDOW_DEPTH]);
      for (int i = 0; i < SHC_WINDOW_DEPTH; i++) begin
         send_word(blk[i]);
      end
   endtask

   // Mostly dense random words, with a share of all-zero, all-one, single-one-bit and single-zero-bit patterns.
   function automatic word_type random_word();
      word_type w;
      case ($urandom_range(0, 7))
         0:       w = '0;
         1:       w = '1;
         2:       w = word_type'(1) << $urandom_range(0, SHC_WORD_W - 1);
         3:       w = ~(word_type'(1) << $urandom_range(0, SHC_WORD_W - 1));
         default: w = $urandom();
      endcase
      return w;
   endfunction

   task automatic send_random_blocks(input int unsigned count);
      word_type blk [SHC_WINDOW_DEPTH];
      for (int b = 0; b < count; b++) begin
         for (int i = 0; i < SHC_WINDOW_DEPTH; i++) begin
            blk[i] = random_word();
         end
         send_block(blk);
      end
   endtask

   task automatic wait_for_digests();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      word_type blk [SHC_WINDOW_DEPTH];
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_message_word = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The padded three-byte message "abc", a block with a well-known digest.
      for (int i = 0; i < SHC_WINDOW_DEPTH; i++) begin
         blk[i] = '0;
      end
      blk[0]                  = 32'h61626380;
      blk[SHC_WINDOW_DEPTH-1] = 32'h00000018;
      send_block(blk);

      // Field extremes: words alternate between all zeros and all ones.
      for (int i = 0; i < SHC_WINDOW_DEPTH; i++) begin
         blk[i] = (i % 2 == 0) ? '0 : '1;
      end
      send_block(blk);

      send_random_blocks(PHASE_BLOCKS - 1);
      wait_for_digests();

      // Swap the idle rates and hold the result side off long enough for the input to back up.
      req_idle_pct = 73;
      rsp_idle_pct = 36;
      hold_request = 1'b1;
      send_random_blocks(PHASE_BLOCKS);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random_blocks(PHASE_BLOCKS);

      wait_for_digests();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("testbench: %0d blocks hashed and %0d digest words compared", blocks_hashed,
               words_checked);
      $display("testbench: covered sparse sender, sparse receiver, no idling and a long hold");
      if (pending_count != 0) begin
         $display("testbench: %0d digest words never arrived", pending_count);
      end
      if (error_count == 0 && pending_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/shc_pkg.sv
rtl/shc_front.sv
rtl/shc_queue.sv
rtl/shc_back.sv
rtl/sha256_single_block_hash_core.sv
test/sha256_checker.sv
test/testbench.sv
